### sv/pmpt_pkg.sv
// ----------------------------------------------------------------------------
// pmpt_pkg
// Shared types, constants and helpers for the mouse packet tracker.
// ----------------------------------------------------------------------------
package pmpt_pkg;

  localparam int DIM_W   = 13;  // screen dimension register width
  localparam int POS_W   = 12;  // cursor coordinate width
  localparam int RAW_W   = 14;  // signed unclamped coordinate width
  localparam int COUNT_W = 16;  // test counter width
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [DIM_W-1:0] CURSOR_EXTENT = 13'd8;
  localparam logic [DIM_W-1:0] POS_MAX       = 13'd4095;
  localparam logic [DIM_W-1:0] WIDTH_RESET   = 13'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RESET  = 13'd768;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TEST_ENABLE   = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] screen_width;
    logic [DIM_W-1:0] screen_height;
    logic             test_enable;
    logic             test_set;   // one-cycle pulse on a write of 1
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       from_aux;
  } byte_req_t;

  // Upper clamp limit for one screen dimension.
  function automatic logic [POS_W-1:0] clamp_limit(input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] diff;
    diff = dim - CURSOR_EXTENT;
    if (dim <= CURSOR_EXTENT) begin
      return '0;
    end else if (diff > POS_MAX) begin
      return POS_MAX[POS_W-1:0];
    end else begin
      return diff[POS_W-1:0];
    end
  endfunction

  // Signed 8-bit value halved toward zero, as a 14-bit signed value.
  function automatic logic [RAW_W-1:0] half_toward_zero(input logic [7:0] b);
    logic [RAW_W-1:0] v;
    logic [RAW_W-1:0] t;
    v = {{(RAW_W-8){b[7]}}, b};
    t = v + {{(RAW_W-1){1'b0}}, v[RAW_W-1]};
    return {t[RAW_W-1], t[RAW_W-1:1]};
  endfunction

  // Clamp a signed raw coordinate to 0..lim.
  function automatic logic [POS_W-1:0] clamp_pos(input logic [RAW_W-1:0] raw,
                                                  input logic [POS_W-1:0] lim);
    if (raw[RAW_W-1]) begin
      return '0;
    end else if (raw[RAW_W-2:0] > {1'b0, lim}) begin
      return lim;
    end else begin
      return raw[POS_W-1:0];
    end
  endfunction

endpackage

### sv/ps2_mouse_packet_tracker_unit.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit
// Three-byte mouse packet decoder with clamped cursor and test counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one controller byte per request, with
//   from_aux marking bytes from the mouse port; other bytes are dropped.
//   The block hunts for a first byte with bit 3 set, then gathers packets.
//   Output channel (out_valid/out_stall): one result per completed packet,
//   carrying clamped cursor position, left button and the test counters.
//   Throughput: one byte per clock while no result is stalled. A byte
//   waits in the input register, then the packet logic loads the result
//   register, where out_valid rises for the third byte of a packet.
//   A single update stage lies between the input register and the
//   result register.
//   When the receiver stalls a waiting result, the packet stage holds and
//   in_stall rises once the input register is also occupied.
//   Configuration goes through the APB port: screen_width at 0x0,
//   screen_height at 0x4, test_enable at 0x8. Writing 1 to test_enable
//   clears both counters and marks the current position as the reference.
//   Reset (rst, synchronous) returns to sync search, cursor at 0,0,
//   counters cleared, screen 1024x768 and test mode off.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_unit
  import pmpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // byte requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               from_aux,
  // packet results
  output logic               out_valid,
  input  logic               out_stall,
  output logic [POS_W-1:0]   cursor_x,
  output logic [POS_W-1:0]   cursor_y,
  output logic               left_pressed,
  output logic [COUNT_W-1:0] click_count,
  output logic [COUNT_W-1:0] move_count
);

  cfg_t      cfg;
  byte_req_t req;
  logic      advance;

  // Register file; test_set pulses for one cycle on a write of 1.
  pmpt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Capture incoming bytes; hold while the packet stage is blocked.
  pmpt_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .from_aux  (from_aux),
    .advance   (advance),
    .req       (req)
  );

  // Advance the packet framing, move the cursor, load the result register.
  pmpt_core u_core (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cfg          (cfg),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cursor_x     (cursor_x),
    .cursor_y     (cursor_y),
    .left_pressed (left_pressed),
    .click_count  (click_count),
    .move_count   (move_count)
  );

endmodule

### sv/pmpt_cfg.sv
// ----------------------------------------------------------------------------
// pmpt_cfg
// APB register file: screen size and test mode control.
// ----------------------------------------------------------------------------
module pmpt_cfg
  import pmpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic             wr_en;
  logic [1:0]       index;
  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;
  logic             test_enable;
  logic             test_set;

  assign pready = 1'b1;
  assign index  = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  // Clear the counters at the same edge that writes test_enable to 1.
  assign test_set = wr_en && (index == REG_TEST_ENABLE) && pwdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
      test_enable   <= 1'b0;
    end else begin
      if (wr_en) begin
        case (index)
          REG_SCREEN_WIDTH:  screen_width  <= pwdata[DIM_W-1:0];
          REG_SCREEN_HEIGHT: screen_height <= pwdata[DIM_W-1:0];
          REG_TEST_ENABLE:   test_enable   <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (index)
      REG_SCREEN_WIDTH:  prdata = {{(DATA_W-DIM_W){1'b0}}, screen_width};
      REG_SCREEN_HEIGHT: prdata = {{(DATA_W-DIM_W){1'b0}}, screen_height};
      REG_TEST_ENABLE:   prdata = {{(DATA_W-1){1'b0}}, test_enable};
      default:           prdata = '0;
    endcase
  end

  assign cfg = '{screen_width:  screen_width,
                 screen_height: screen_height,
                 test_enable:   test_enable,
                 test_set:      test_set};

endmodule

### sv/pmpt_in_reg.sv
// ----------------------------------------------------------------------------
// pmpt_in_reg
// Input register for controller bytes.
// ----------------------------------------------------------------------------
module pmpt_in_reg
  import pmpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [7:0] data_byte,
  input  logic      from_aux,
  input  logic      advance,
  output byte_req_t req
);

  logic       valid;
  logic [7:0] data;
  logic       aux;

  // Hold while the byte in the register cannot move on.
  assign in_stall = valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data <= data_byte;
      aux  <= from_aux;
    end
  end

  assign req = '{valid: valid, data_byte: data, from_aux: aux};

endmodule

### sv/pmpt_core.sv
// ----------------------------------------------------------------------------
// pmpt_core
// Packet framing, cursor update, test counters and result register.
// ----------------------------------------------------------------------------
module pmpt_core
  import pmpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  byte_req_t          req,
  input  cfg_t               cfg,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [POS_W-1:0]   cursor_x,
  output logic [POS_W-1:0]   cursor_y,
  output logic               left_pressed,
  output logic [COUNT_W-1:0] click_count,
  output logic [COUNT_W-1:0] move_count
);

  typedef enum logic [1:0] {
    PH_SYNC   = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2,
    PH_UNUSED = 2'd3
  } phase_t;

  phase_t             byte_phase;
  logic               first_button_bit;
  logic [7:0]         held_dx_byte;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic               button_now;
  logic [COUNT_W-1:0] clicks;
  logic [COUNT_W-1:0] moves;
  logic [RAW_W-1:0]   prev_raw_x;
  logic [RAW_W-1:0]   prev_raw_y;

  logic               take;
  logic               finish;
  logic [RAW_W-1:0]   dx;
  logic [RAW_W-1:0]   dy;
  logic [RAW_W-1:0]   raw_x;
  logic [RAW_W-1:0]   raw_y;
  logic [POS_W-1:0]   pos_x_next;
  logic [POS_W-1:0]   pos_y_next;
  logic               click_hit;
  logic               move_hit;
  logic [COUNT_W-1:0] clicks_next;
  logic [COUNT_W-1:0] moves_next;

  assign advance = !out_valid || !out_stall;
  assign take    = advance && req.valid && req.from_aux;
  assign finish  = take && (byte_phase == PH_DY);

  always_comb begin
    dx         = half_toward_zero(held_dx_byte);
    dy         = '0 - half_toward_zero(req.data_byte);
    raw_x      = {{(RAW_W-POS_W){1'b0}}, pos_x} + dx;
    raw_y      = {{(RAW_W-POS_W){1'b0}}, pos_y} + dy;
    pos_x_next = clamp_pos(raw_x, clamp_limit(cfg.screen_width));
    pos_y_next = clamp_pos(raw_y, clamp_limit(cfg.screen_height));
    click_hit  = cfg.test_enable && !button_now && first_button_bit;
    move_hit   = cfg.test_enable && ((raw_x != prev_raw_x) || (raw_y != prev_raw_y));
    clicks_next = click_hit ? clicks + 1'b1 : clicks;
    moves_next  = move_hit ? moves + 1'b1 : moves;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase       <= PH_SYNC;
      first_button_bit <= 1'b0;
      held_dx_byte     <= '0;
      pos_x            <= '0;
      pos_y            <= '0;
      button_now       <= 1'b0;
      clicks           <= '0;
      moves            <= '0;
      prev_raw_x       <= '0;
      prev_raw_y       <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= finish;
      end
      if (cfg.test_set) begin
        clicks     <= '0;
        moves      <= '0;
        prev_raw_x <= {{(RAW_W-POS_W){1'b0}}, pos_x};
        prev_raw_y <= {{(RAW_W-POS_W){1'b0}}, pos_y};
      end else if (take) begin
        case (byte_phase)
          PH_DX: begin
            held_dx_byte <= req.data_byte;
            byte_phase   <= PH_DY;
          end
          PH_DY: begin
            byte_phase <= PH_SYNC;
            button_now <= first_button_bit;
            clicks     <= clicks_next;
            moves      <= moves_next;
            if (move_hit) begin
              prev_raw_x <= raw_x;
              prev_raw_y <= raw_y;
            end
            pos_x <= pos_x_next;
            pos_y <= pos_y_next;
          end
          default: begin
            // sync search: a first byte needs bit 3 set
            if (req.data_byte[3]) begin
              first_button_bit <= req.data_byte[0];
              byte_phase       <= PH_DX;
            end else begin
              byte_phase <= PH_SYNC;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      cursor_x     <= pos_x_next;
      cursor_y     <= pos_y_next;
      left_pressed <= first_button_bit;
      click_count  <= clicks_next;
      move_count   <= moves_next;
    end
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PS/2 mouse packet tracker.
// Drives controller bytes through the valid/stall request channel, programs
// the screen size and test mode over APB, and tracks every accepted byte in
// a local packet decoder. Each result leaving the block is compared field by
// field with the oldest predicted packet. Directed cases come first, then
// random packet traffic under several idling mixes and a long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_top
  import pmpt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CURSOR_PIX = 8;     // cursor extent used by the clamp
  localparam int POS_TOP    = 4095;  // largest cursor coordinate
  localparam int SETTLE_CYC = 8;     // idle padding after the last result

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,  // looking for a first byte with bit 3 set
    PH_DX   = 2'd1,  // next mouse byte is the X delta
    PH_DY   = 2'd2   // next mouse byte is the Y delta and closes the packet
  } pkt_phase_e;

  typedef struct {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic               btn;
    logic [COUNT_W-1:0] clicks;
    logic [COUNT_W-1:0] moves;
  } pkt_result_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [ADDR_W-1:0]  paddr     = '0;
  logic [DATA_W-1:0]  pwdata    = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = '0;
  logic               from_aux  = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [POS_W-1:0]   cursor_x;
  logic [POS_W-1:0]   cursor_y;
  logic               left_pressed;
  logic [COUNT_W-1:0] click_count;
  logic [COUNT_W-1:0] move_count;

  ps2_mouse_packet_tracker_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .from_aux     (from_aux),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cursor_x     (cursor_x),
    .cursor_y     (cursor_y),
    .left_pressed (left_pressed),
    .click_count  (click_count),
    .move_count   (move_count)
  );

  // --------------------------------------------------------------------------
  // Bench control
  // --------------------------------------------------------------------------
  int tx_idle_pct = 0;   // chance in 100 that the sender skips a cycle
  int rx_idle_pct = 0;   // chance in 100 that the receiver stalls a cycle
  int hold_len    = 0;   // cycles of forced receiver stall, consumed by rx side
  int fail_count  = 0;

  pkt_result_t pending_packets[$];

  // Local copy of the block's registers and packet state
  logic [DIM_W-1:0]   scr_w;
  logic [DIM_W-1:0]   scr_h;
  logic               test_on;
  pkt_phase_e         phase;
  logic               btn_first;
  logic [7:0]         dx_byte;
  int                 pos_x;
  int                 pos_y;
  logic               btn_now;
  logic [COUNT_W-1:0] clicks;
  logic [COUNT_W-1:0] moves;
  int                 prev_rx;
  int                 prev_ry;

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Packet decoder used for prediction
  // --------------------------------------------------------------------------
  function automatic int clamp_top(input logic [DIM_W-1:0] dim);
    int d;
    d = dim;
    if (d <= CURSOR_PIX) return 0;
    if (d - CURSOR_PIX > POS_TOP) return POS_TOP;
    return d - CURSOR_PIX;
  endfunction

  function automatic int clamp_coord(input int v, input logic [DIM_W-1:0] dim);
    int top;
    top = clamp_top(dim);
    if (v < 0) return 0;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void reset_tracker();
    scr_w     = WIDTH_RESET;
    scr_h     = HEIGHT_RESET;
    test_on   = 1'b0;
    phase     = PH_HUNT;
    btn_first = 1'b0;
    dx_byte   = '0;
    pos_x     = 0;
    pos_y     = 0;
    btn_now   = 1'b0;
    clicks    = '0;
    moves     = '0;
    prev_rx   = 0;
    prev_ry   = 0;
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    case (idx)
      REG_SCREEN_WIDTH:  scr_w = val[DIM_W-1:0];
      REG_SCREEN_HEIGHT: scr_h = val[DIM_W-1:0];
      REG_TEST_ENABLE: begin
        test_on = val[0];
        // a write of 1 restarts both counters from the current position
        if (test_on) begin
          clicks  = '0;
          moves   = '0;
          prev_rx = pos_x;
          prev_ry = pos_y;
        end
      end
      default: ;
    endcase
  endfunction

  // Advance the decoder by one accepted request; queue a packet on byte three.
  function automatic void track_byte(input logic [7:0] b, input logic aux);
    int          sx;
    int          sy;
    int          rx;
    int          ry;
    logic        old_btn;
    pkt_result_t r;
    if (!aux) return;
    case (phase)
      PH_DX: begin
        dx_byte = b;
        phase   = PH_DY;
      end
      PH_DY: begin
        phase   = PH_HUNT;
        old_btn = btn_now;
        btn_now = btn_first;
        if (test_on && !old_btn && btn_now) clicks = clicks + 1'b1;
        sx = $signed(dx_byte);
        sy = $signed(b);
        rx = pos_x + sx / 2;
        ry = pos_y + (-sy) / 2;
        if (test_on && (rx != prev_rx || ry != prev_ry)) begin
          moves   = moves + 1'b1;
          prev_rx = rx;
          prev_ry = ry;
        end
        pos_x    = clamp_coord(rx, scr_w);
        pos_y    = clamp_coord(ry, scr_h);
        r.x      = pos_x[POS_W-1:0];
        r.y      = pos_y[POS_W-1:0];
        r.btn    = btn_now;
        r.clicks = clicks;
        r.moves  = moves;
        pending_packets.push_back(r);
      end
      default: begin
        // drop anything that cannot start a packet and keep hunting
        if (b[3]) begin
          btn_first = b[0];
          phase     = PH_DX;
        end else begin
          phase = PH_HUNT;
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Offer one byte request; return at the edge that accepts it, valid still high.
  task automatic offer_byte(input logic [7:0] b, input logic aux);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    from_aux  <= aux;
    do @(posedge clk); while (in_stall);
    track_byte(b, aux);
  endtask

  task automatic offer_packet(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2);
    offer_byte(b0, 1'b1);
    offer_byte(b1, 1'b1);
    offer_byte(b2, 1'b1);
  endtask

  // Drop valid, wait for every predicted packet, then let the pipe settle.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_packets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle held until pready.
  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_reg(idx, val);
  endtask

  // Screen dimension with the clamp corners weighted in.
  function automatic logic [DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return CURSOR_PIX;
      2:       return CURSOR_PIX + 1;
      3:       return 16;
      4:       return 640;
      5:       return 4096;
      6:       return POS_TOP + CURSOR_PIX;
      7:       return POS_TOP + CURSOR_PIX + 1;
      8:       return 8191;
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  // Large delta toward one side most of the time so the edges get hit.
  function automatic logic [7:0] pick_delta(input bit grow);
    if ($urandom_range(0, 99) < 30) return 8'($urandom_range(0, 255));
    if (grow) return 8'($urandom_range(64, 127));
    return 8'($urandom_range(128, 192));
  endfunction

  // Mostly well-formed packets; some keyboard noise and stray mouse bytes.
  task automatic run_traffic(input int n_aux);
    int     sent;
    int     kind;
    bit     drift_x;
    bit     drift_y;
    logic [7:0] b0;
    sent    = 0;
    drift_x = 1'($urandom_range(0, 1));
    drift_y = 1'($urandom_range(0, 1));
    while (sent < n_aux) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        offer_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 20) begin
        offer_byte(8'($urandom_range(0, 255)), 1'b1);
        sent++;
      end else begin
        b0    = 8'($urandom_range(0, 255));
        b0[3] = 1'b1;
        offer_packet(b0, pick_delta(drift_x), pick_delta(drift_y));
        sent += 3;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall, with an optional long hold-off
  // --------------------------------------------------------------------------
  initial begin : rx_side
    int n;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
        repeat (n) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result check against the oldest predicted packet
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_packets
    pkt_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_packets.size() == 0) begin
        $error("packet result with none predicted: x=%0d y=%0d", cursor_x, cursor_y);
        fail_count++;
      end else begin
        want = pending_packets.pop_front();
        if (cursor_x !== want.x) begin
          $error("cursor_x: expected %0d, got %0d", want.x, cursor_x);
          fail_count++;
        end
        if (cursor_y !== want.y) begin
          $error("cursor_y: expected %0d, got %0d", want.y, cursor_y);
          fail_count++;
        end
        if (left_pressed !== want.btn) begin
          $error("left_pressed: expected %0d, got %0d", want.btn, left_pressed);
          fail_count++;
        end
        if (click_count !== want.clicks) begin
          $error("click_count: expected %0d, got %0d", want.clicks, click_count);
          fail_count++;
        end
        if (move_count !== want.moves) begin
          $error("move_count: expected %0d, got %0d", want.moves, move_count);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Sync hunt, keyboard bytes mixed into a packet, delta extremes.
  task automatic test_sync_and_noise();
    offer_byte(8'h00, 1'b1);   // no bit 3: stay hunting
    offer_byte(8'hF7, 1'b1);   // all bits but bit 3: stay hunting
    offer_byte(8'hFF, 1'b0);   // keyboard byte: ignored
    offer_packet(8'h09, 8'h7F, 8'h80);
    offer_byte(8'h08, 1'b1);
    offer_byte(8'h55, 1'b0);
    offer_byte(8'h80, 1'b1);
    offer_byte(8'hAA, 1'b0);
    offer_byte(8'h7F, 1'b1);
    // minus one in X and plus one in Y both halve to zero
    offer_packet(8'hFF, 8'hFF, 8'h01);
  endtask

  // Screen at and just past the cursor size, then a screen past the coordinate range.
  task automatic test_clamp_corners();
    drain_block();
    reg_write(REG_SCREEN_WIDTH, CURSOR_PIX);
    reg_write(REG_SCREEN_HEIGHT, CURSOR_PIX + 1);
    offer_packet(8'h08, 8'h7F, 8'h80);
    drain_block();
    reg_write(REG_SCREEN_WIDTH, 8191);
    reg_write(REG_SCREEN_HEIGHT, POS_TOP + CURSOR_PIX + 1);
    offer_packet(8'h08, 8'h7F, 8'h80);
  endtask

  // Press, hold still, release with test mode on.
  task automatic test_counters();
    drain_block();
    reg_write(REG_TEST_ENABLE, 1);
    offer_packet(8'h09, 8'h04, 8'h00);
    offer_packet(8'h09, 8'h00, 8'h01);
    offer_packet(8'h08, 8'hFC, 8'h01);
    drain_block();
    reg_write(REG_TEST_ENABLE, 0);
  endtask

  // Random traffic under one idling mix, reprogramming between segments.
  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (4) begin
      drain_block();
      reg_write(REG_SCREEN_WIDTH, pick_dim());
      reg_write(REG_SCREEN_HEIGHT, pick_dim());
      reg_write(REG_TEST_ENABLE, $urandom_range(0, 1));
      run_traffic(40);
    end
  endtask

  // Hold the receiver off long enough that the block backs up into in_stall.
  task automatic test_backpressure();
    drain_block();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    reg_write(REG_TEST_ENABLE, 1);
    hold_len = 300;
    run_traffic(90);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_tracker();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_sync_and_noise();
    test_clamp_corners();
    test_counters();
    test_random_traffic(36, 78);
    test_random_traffic(78, 36);
    test_random_traffic(0, 0);
    test_backpressure();

    drain_block();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
